[hw/rtl/deq_pkg.sv]
package deq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int WORD_W     = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		K_PUSH_FRONT = 3'd0,
		K_PUSH_BACK  = 3'd1,
		K_POP_FRONT  = 3'd2,
		K_POP_BACK   = 3'd3,
		K_PEEK_FRONT = 3'd4,
		K_PEEK_BACK  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// decoded operation handed from the front part to the back part
	typedef struct packed {
		logic                  is_push;
		logic                  is_take;
		logic                  at_back;
		logic                  removes;
		logic [DATA_WIDTH-1:0] word;
	} op_t;

	typedef enum logic {
		B_RUN,
		B_READ
	} bst_t;

	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
			input logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		s = {1'b0, idx} + {1'b0, off};
		if (s >= (IDX_W+1)'(DEPTH)) begin
			s = s - (IDX_W+1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

[hw/rtl/deq_front.sv]
module deq_front import deq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       kind,
	input  logic [WORD_W-1:0] word_in,
	output logic             q_valid,
	output op_t              q_op,
	input  logic             q_pop
);

	op_t        fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	op_t        op_in;
	logic       push;

	// classify the incoming transaction
	always_comb begin
		op_in = '0;
		op_in.word = word_in[DATA_WIDTH-1:0];
		case (kind)
			K_PUSH_FRONT: op_in.is_push = 1'b1;
			K_PUSH_BACK: begin
				op_in.is_push = 1'b1;
				op_in.at_back = 1'b1;
			end
			K_POP_FRONT: begin
				op_in.is_take = 1'b1;
				op_in.removes = 1'b1;
			end
			K_POP_BACK: begin
				op_in.is_take = 1'b1;
				op_in.removes = 1'b1;
				op_in.at_back = 1'b1;
			end
			K_PEEK_FRONT: op_in.is_take = 1'b1;
			K_PEEK_BACK: begin
				op_in.is_take = 1'b1;
				op_in.at_back = 1'b1;
			end
			default: ;
		endcase
	end

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != 2'd0);
	assign q_op     = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

[hw/rtl/deq_back.sv]
module deq_back import deq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  op_t               q_op,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] word_out,
	output logic [1:0]        status,
	output logic [CNT_W-1:0]  fill_count
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;
	bst_t                  state_q, state_d;
	logic [IDX_W-1:0]      front_q, front_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic                  out_valid_q;
	logic [WORD_W-1:0]     word_q;
	status_t               status_q;
	logic [CNT_W-1:0]      fill_q;
	logic                  out_free;
	logic                  mem_we, mem_re;
	logic [IDX_W-1:0]      wr_idx, rd_idx;
	logic [IDX_W-1:0]      front_dec, tail_idx, last_idx;
	logic                  ld_out;
	logic [DATA_WIDTH-1:0] ld_word;
	status_t               ld_status;
	logic                  is_full, is_empty;

	assign out_free  = !out_valid_q || out_ready;
	assign is_full   = (cnt_q == CNT_W'(DEPTH));
	assign is_empty  = (cnt_q == '0);
	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
	assign tail_idx  = wrap_add(front_q, cnt_q[IDX_W-1:0]);
	assign last_idx  = wrap_add(front_q, IDX_W'(cnt_q - 1'b1));

	always_comb begin
		state_d   = state_q;
		front_d   = front_q;
		cnt_d     = cnt_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		wr_idx    = tail_idx;
		rd_idx    = front_q;
		ld_out    = 1'b0;
		ld_word   = '0;
		ld_status = ST_OK;
		case (state_q)
			B_RUN: begin
				if (q_valid && out_free) begin
					q_pop  = 1'b1;
					ld_out = 1'b1;
					if (q_op.is_push) begin
						if (is_full) begin
							ld_status = ST_FULL;
						end else begin
							mem_we = 1'b1;
							cnt_d  = cnt_q + 1'b1;
							if (!q_op.at_back) begin
								wr_idx  = front_dec;
								front_d = front_dec;
							end
						end
					end else if (q_op.is_take) begin
						if (is_empty) begin
							ld_status = ST_EMPTY;
						end else begin
							// word arrives from the store next cycle
							ld_out  = 1'b0;
							mem_re  = 1'b1;
							state_d = B_READ;
							rd_idx  = q_op.at_back ? last_idx : front_q;
							if (q_op.removes) begin
								cnt_d = cnt_q - 1'b1;
								if (!q_op.at_back) begin
									front_d = wrap_add(front_q, IDX_W'(1));
								end
							end
						end
					end
				end
			end
			B_READ: begin
				if (out_free) begin
					ld_out  = 1'b1;
					ld_word = rdata_q;
					state_d = B_RUN;
				end
			end
			default: state_d = B_RUN;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx] <= q_op.word;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			word_q   <= WORD_W'(ld_word);
			status_q <= ld_status;
			fill_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_RUN;
			front_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			cnt_q   <= cnt_d;
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign word_out   = word_q;
	assign status     = status_q;
	assign fill_count = fill_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("element count beyond depth");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("accepted push did not bump count");

	a_read_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ) |-> ($past(mem_re) || $past(state_q == B_READ)))
		else $error("read wait without a store read");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(word_q)))
		else $error("stalled result lost");

endmodule

[hw/rtl/double_ended_queue.sv]
// channel | direction | handshake              | payload
// --------+-----------+------------------------+----------------------------
// in      | in        | in_valid / in_ready    | kind, word_in
// out     | out       | out_valid / out_ready  | word_out, status, fill_count
//
// pushes and refused requests are answered straight from the run state, pops
// and peeks pass through a wait state for the registered read of the store
// a two-entry queue after the front end absorbs up to two transactions while
// results stall, then in_ready drops until the back end takes one
// each result is held in an output register until out_ready takes it
// arst_n clears front index, element count and all handshake state; the
// slot store itself is not reset and is read only at occupied slots
module double_ended_queue import deq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        kind,
	input  logic [WORD_W-1:0] word_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] word_out,
	output logic [1:0]        status,
	output logic [CNT_W-1:0]  fill_count
);

	// decoded operations waiting between the two halves
	logic q_valid;
	op_t  q_op;
	logic q_pop;

	// front end: takes each transaction, decodes the kind, queues it
	deq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.word_in  (word_in),
		.q_valid  (q_valid),
		.q_op     (q_op),
		.q_pop    (q_pop)
	);

	// back end: owns the ring store, front index and count, builds results
	deq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_op       (q_op),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word_out   (word_out),
		.status     (status),
		.fill_count (fill_count)
	);

endmodule

[verif/double_ended_queue_tb.sv]
module double_ended_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	// kinds the block decodes as a no-operation
	localparam logic [2:0] K_UNUSED_LO = 3'd6;
	localparam logic [2:0] K_UNUSED_HI = 3'd7;

	localparam int RANDOM_ITEMS = 1850;
	// quiet cycles allowed before the run is declared hung
	localparam int QUIET_LIMIT  = 5000;
	// receiver hold-off long enough to back the block up into in_ready
	localparam int LONG_HOLD    = 120;
	localparam int TAIL_CYCLES  = 20;

	// traffic mix of the random part, changed every few dozen transactions
	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_t;

	// tracks the deque contents and the results they imply
	class deque_scoreboard;
		typedef struct {
			logic [WORD_W-1:0] word;
			status_t           st;
			logic [CNT_W-1:0]  cnt;
		} outcome_t;

		logic [DATA_WIDTH-1:0] slots [DEPTH];
		int                    front;
		int                    count;
		outcome_t              pending_results [$];
		int                    failures;

		function new();
			front    = 0;
			count    = 0;
			failures = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= 10) begin
				$display("%0t ns: %s", $realtime, msg);
			end
		endfunction

		// apply one accepted request and queue the result it must produce
		function void note_request(logic [2:0] k, logic [WORD_W-1:0] w);
			outcome_t res;
			int       slot;
			res.word = '0;
			res.st   = ST_OK;
			case (k)
				K_PUSH_FRONT, K_PUSH_BACK: begin
					if (count >= DEPTH) begin
						res.st = ST_FULL;
					end else begin
						if (k == K_PUSH_FRONT) begin
							front = (front + DEPTH - 1) % DEPTH;
							slot  = front;
						end else begin
							slot = (front + count) % DEPTH;
						end
						slots[slot] = w[DATA_WIDTH-1:0];
						count++;
					end
				end
				K_POP_FRONT, K_POP_BACK, K_PEEK_FRONT, K_PEEK_BACK: begin
					if (count == 0) begin
						res.st = ST_EMPTY;
					end else begin
						if (k == K_POP_FRONT || k == K_PEEK_FRONT) begin
							slot = front;
						end else begin
							slot = (front + count - 1) % DEPTH;
						end
						res.word = WORD_W'(slots[slot]);
						if (k == K_POP_FRONT) begin
							front = (front + 1) % DEPTH;
						end
						if (k == K_POP_FRONT || k == K_POP_BACK) begin
							count--;
						end
					end
				end
				default: begin
				end
			endcase
			res.cnt = CNT_W'(count);
			pending_results.push_back(res);
		endfunction

		function void check_result(logic [WORD_W-1:0] w, logic [1:0] st,
				logic [CNT_W-1:0] cnt);
			outcome_t want;
			if (pending_results.size() == 0) begin
				flag($sformatf("unexpected result: word %h st %0d cnt %0d",
					w, st, cnt));
				return;
			end
			want = pending_results.pop_front();
			if (w !== want.word || st !== want.st || cnt !== want.cnt) begin
				flag($sformatf("expected %h/%0d/%0d, got %h/%0d/%0d",
					want.word, want.st, want.cnt, w, st, cnt));
			end
		endfunction
	endclass

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic [2:0]        kind       = '0;
	logic [WORD_W-1:0] word_in    = '0;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	logic [WORD_W-1:0] word_out;
	logic [1:0]        status;
	logic [CNT_W-1:0]  fill_count;

	deque_scoreboard sb = new();
	int              quiet_cycles = 0;
	// result counts at which the receiver goes quiet for a long stretch
	int              hold_marks [$] = '{400, 1300};

	double_ended_queue u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.word_in    (word_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word_out   (word_out),
		.status     (status),
		.fill_count (fill_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [2:0] pick_kind(mix_t mix);
		int r;
		int push_share;
		r = $urandom_range(99);
		case (mix)
			MIX_FILL:  push_share = 70;
			MIX_DRAIN: push_share = 20;
			default:   push_share = 45;
		endcase
		// a sprinkle of the undecoded kinds
		if (r < 3) return ($urandom_range(1) != 0) ? K_UNUSED_HI : K_UNUSED_LO;
		if (r < 3 + push_share) begin
			return ($urandom_range(1) != 0) ? K_PUSH_BACK : K_PUSH_FRONT;
		end
		case ($urandom_range(3))
			0:       return K_POP_FRONT;
			1:       return K_POP_BACK;
			2:       return K_PEEK_FRONT;
			default: return K_PEEK_BACK;
		endcase
	endfunction

	// extremes of the data word show up often next to full random values
	function automatic logic [WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return WORD_W'($urandom());
	endfunction

	// offer one transaction and hold it until the block takes it
	task automatic send_req(logic [2:0] k, logic [WORD_W-1:0] w);
		in_valid <= 1'b1;
		kind     <= k;
		word_in  <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid for a while, with junk on the payload lines
	task automatic idle_for(int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			kind     <= 3'($urandom());
			word_in  <= WORD_W'($urandom());
			repeat (cycles) @(posedge clk);
		end
	endtask

	// sender pause: nothing offered until every result is back
	task automatic drain_wait();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// both channels are sampled at the edge, before any update from it lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_request(kind, word_in);
			end
			if (out_valid && out_ready) begin
				sb.check_result(word_out, status, fill_count);
			end
		end
	end

	// hang detector: any transaction on either side resets the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("double_ended_queue_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random stalls, steady stretches, and the long hold-offs
	initial begin : result_sink
		int seen;
		int stall_left;
		int steady_left;
		int r;
		seen        = 0;
		stall_left  = 0;
		steady_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				seen++;
			end
			if (hold_marks.size() != 0 && seen >= hold_marks[0]) begin
				void'(hold_marks.pop_front());
				stall_left  = LONG_HOLD;
				steady_left = 0;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (steady_left > 0) begin
				out_ready <= 1'b1;
				steady_left--;
			end else begin
				out_ready <= 1'b1;
				r = $urandom_range(99);
				if (r < 5) begin
					steady_left = $urandom_range(30, 100);
				end else if (r < 30) begin
					stall_left = gap_len();
				end
			end
		end
	end

	initial begin : stimulus
		mix_t mix;
		bit   no_idle;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: refused take and peek, then the undecoded kinds
		send_req(K_POP_FRONT, '1);
		send_req(K_PEEK_BACK, '0);
		send_req(K_UNUSED_LO, '1);
		send_req(K_UNUSED_HI, '0);

		// fill to capacity from both ends, extreme words first
		for (int i = 0; i < DEPTH; i++) begin
			case (i)
				0:       send_req(K_PUSH_FRONT, '0);
				1:       send_req(K_PUSH_BACK, '1);
				2:       send_req(K_PUSH_FRONT, {(WORD_W/2){2'b10}});
				3:       send_req(K_PUSH_BACK, {(WORD_W/2){2'b01}});
				default: send_req((i % 2 != 0) ? K_PUSH_BACK : K_PUSH_FRONT, pick_word());
			endcase
		end

		// full queue: both pushes refused and the word dropped
		send_req(K_PUSH_FRONT, '1);
		send_req(K_PUSH_BACK, '0);

		// both ends read without and with removal
		send_req(K_PEEK_FRONT, pick_word());
		send_req(K_PEEK_BACK, pick_word());
		send_req(K_POP_FRONT, pick_word());
		send_req(K_POP_BACK, pick_word());
		drain_wait();

		// random part: phases that push toward full, toward empty, or hover
		mix     = MIX_EVEN;
		no_idle = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(2))
					0:       mix = MIX_FILL;
					1:       mix = MIX_DRAIN;
					default: mix = MIX_EVEN;
				endcase
				no_idle = ($urandom_range(3) == 0);
			end
			if (n == RANDOM_ITEMS / 2) begin
				drain_wait();
			end
			send_req(pick_kind(mix), pick_word());
			if (!no_idle) begin
				idle_for(gap_len());
			end
		end

		// let the last results come out, then a short quiet tail
		drain_wait();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("double_ended_queue_tb OK");
		end else begin
			$display("double_ended_queue_tb NOT OK");
		end
		$finish;
	end

endmodule
